// ===== rtl/core/buddy_page_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// buddy page allocator check macros
// assertion forms used by bpa_engine
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// condition that holds at every clock edge
`define BPA_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("bpa check failed");

// condition that holds in the cycle after a trigger
`define BPA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpa check failed");

`endif

// ===== rtl/core/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg
// types and constants shared by the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int PAGE_FIELD_W  = 12;
  localparam int ORDER_FIELD_W = 4;
  localparam int TOTAL_W       = 13;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RANGE = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                 opcode;
    logic [PAGE_FIELD_W-1:0] page_number;
    logic [31:0]             base_address;
    logic [31:0]             byte_count;
  } request_t;

  typedef struct packed {
    logic                     status;
    logic [PAGE_FIELD_W-1:0]  granted_page;
    logic [ORDER_FIELD_W-1:0] granted_order;
    logic [TOTAL_W-1:0]       free_page_total;
  } response_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_AORD, S_ASCAN, S_ARD, S_SPLIT, S_AFIN_RD, S_AFIN_WR,
    S_F_RD, S_F_CHK, S_R_CHK, S_R_BLK, S_R_NEXT, S_ADD, S_ADD_CHK,
    S_ADD_LOOP, S_BUD_CHK, S_MERGE, S_INS, S_INS_RD, S_INS_WR, S_RM0,
    S_RMP_RD, S_RMP_WR, S_RMN_RD, S_RMN_WR, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CTX_FREE, CTX_SPLIT, CTX_RANGE
  } add_ctx_t;

  typedef enum logic {
    RET_ALLOC, RET_MERGE
  } rm_ret_t;

  typedef struct packed {
    logic start;
    logic rsp_free;
  } eng_in_t;

  typedef struct packed {
    logic idle;
    logic done;
  } eng_out_t;

endpackage

// ===== rtl/core/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_ram
// single write port, single registered read port memory
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bpa_engine.sv =====
// ----------------------------------------------------------------------------
// bpa_engine
// free list sequencer over the per-page memory: allocate, free, range free
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_defines.svh"

module bpa_engine import bpa_pkg::*; #(
  parameter int NUM_PAGES = 4096,
  parameter int ORDER_LEVELS = 11,
  parameter int PAGE_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  eng_in_t   ctl,
  input  request_t  req,
  output eng_out_t  sts,
  output response_t rsp
);

  localparam int PW = $clog2(NUM_PAGES);
  localparam int LW = PW + 1;
  localparam int OW = $clog2(ORDER_LEVELS + 1);
  localparam int IW = (ORDER_LEVELS > 1) ? $clog2(ORDER_LEVELS) : 1;
  localparam int XW = ((PW > ORDER_LEVELS) ? PW : ORDER_LEVELS) + 1;
  localparam int AW = 34;
  localparam int EW = 1 + OW + 2 * LW;

  localparam logic [LW-1:0] NIL  = LW'(NUM_PAGES);
  localparam logic [OW-1:0] MAXO = OW'(ORDER_LEVELS);
  localparam logic [OW-1:0] TOPO = OW'(ORDER_LEVELS - 1);
  localparam logic [AW-1:0] MASK = AW'((1 << PAGE_BITS) - 1);

  typedef struct packed {
    logic          used;
    logic [OW-1:0] ord;
    logic [LW-1:0] prev;
    logic [LW-1:0] next;
  } entry_t;

  state_t state, state_next;
  logic [PW-1:0] clr;
  logic [AW-1:0] pages, rstart, rend;
  logic [XW-1:0] pg, pfn, n;
  logic [OW-1:0] ord, aord, h, al, mx;
  logic [PW-1:0] blk, rv;
  logic [LW-1:0] rp, rn, ih;
  add_ctx_t ctx;
  rm_ret_t rret;
  logic [LW-1:0] list_head [ORDER_LEVELS];
  logic [LW-1:0] list_count [ORDER_LEVELS];
  logic [TOTAL_W-1:0] total;
  logic status;
  logic [PW-1:0] gpage;
  logic [OW-1:0] gorder;

  logic we;
  logic [PW-1:0] waddr, raddr;
  entry_t wdata, rd;
  logic [EW-1:0] rdata_raw;

  bpa_ram #(.WIDTH(EW), .DEPTH(NUM_PAGES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rd = entry_t'(rdata_raw);

  // helpers
  logic [XW-1:0] bud, split_pg, pfn_sh, al_pow;
  logic bud_ok, rm_ok, aord_step, al_step, mx_step, cnt_zero;
  logic [LW-1:0] ins_head, scan_head;
  logic [OW-1:0] r_min, h_dec;
  logic [AW-1:0] pfn_start, plast, lastc;
  logic r_empty, r_out;
  state_t add_ret, rm_ret;

  assign bud       = pg ^ (XW'(1) << ord);
  assign bud_ok    = bud < XW'(NUM_PAGES);
  assign rm_ok     = rd.ord < MAXO;
  assign ins_head  = list_head[ord[IW-1:0]];
  assign scan_head = list_head[h[IW-1:0]];
  assign cnt_zero  = list_count[h[IW-1:0]] == '0;
  assign aord_step = (aord < MAXO) && ((AW'(1) << aord) < pages);
  assign pfn_sh    = pfn >> al;
  assign al_step   = (al < TOPO) && !pfn_sh[0];
  assign mx_step   = (XW'(1) << mx) > n;
  assign r_min     = (al > mx) ? mx : al;
  assign al_pow    = XW'(1) << al;
  assign h_dec     = h - OW'(1);
  assign split_pg  = XW'(blk) + (XW'(1) << h_dec);
  assign pfn_start = rstart >> PAGE_BITS;
  assign plast     = rend >> PAGE_BITS;
  assign r_empty   = rend <= rstart;
  assign r_out     = pfn_start >= AW'(NUM_PAGES);
  assign lastc     = (plast > AW'(NUM_PAGES)) ? AW'(NUM_PAGES) : plast;

  always_comb begin
    case (ctx)
      CTX_SPLIT: add_ret = S_SPLIT;
      CTX_RANGE: add_ret = S_R_NEXT;
      default:   add_ret = S_DONE;
    endcase
  end

  assign rm_ret = (rret == RET_ALLOC) ? S_SPLIT : S_MERGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = rv;
    wdata      = rd;
    raddr      = rv;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr;
        wdata = '0;
        if (clr == PW'(NUM_PAGES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (ctl.start) begin
          unique case (req.opcode)
            OP_ALLOC: state_next = S_AORD;
            OP_FREE: begin
              if (32'(req.page_number) < 32'(NUM_PAGES)) begin
                state_next = S_F_RD;
              end else begin
                state_next = S_DONE;
              end
            end
            OP_RANGE: state_next = S_R_CHK;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_AORD: begin
        if (!aord_step) begin
          state_next = S_ASCAN;
        end
      end
      S_ASCAN: begin
        if (h < MAXO && cnt_zero) begin
          state_next = S_ASCAN;
        end else if (h < MAXO && scan_head < NIL) begin
          state_next = S_ARD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_ARD: state_next = S_RM0;
      S_SPLIT: begin
        if (h > aord) begin
          state_next = S_ADD;
        end else begin
          state_next = S_AFIN_RD;
        end
      end
      S_AFIN_RD: begin
        raddr      = blk;
        state_next = S_AFIN_WR;
      end
      S_AFIN_WR: begin
        we         = 1'b1;
        waddr      = blk;
        wdata      = rd;
        wdata.ord  = aord;
        state_next = S_DONE;
      end
      S_F_RD: begin
        raddr      = pg[PW-1:0];
        state_next = S_F_CHK;
      end
      S_F_CHK: begin
        if (rd.used || !rm_ok) begin
          state_next = S_DONE;
        end else begin
          state_next = S_ADD_LOOP;
        end
      end
      S_R_CHK: begin
        if (r_empty || r_out) begin
          state_next = S_DONE;
        end else begin
          state_next = S_R_BLK;
        end
      end
      S_R_BLK: begin
        if (!al_step && !mx_step) begin
          state_next = S_ADD;
        end
      end
      S_R_NEXT: begin
        if (n == al_pow) begin
          state_next = S_DONE;
        end else begin
          state_next = S_R_BLK;
        end
      end
      S_ADD: begin
        raddr = pg[PW-1:0];
        if (pg < XW'(NUM_PAGES) && ord < MAXO) begin
          state_next = S_ADD_CHK;
        end else begin
          state_next = add_ret;
        end
      end
      S_ADD_CHK: begin
        if (rd.used) begin
          state_next = add_ret;
        end else begin
          state_next = S_ADD_LOOP;
        end
      end
      S_ADD_LOOP: begin
        raddr = bud[PW-1:0];
        if (ord < TOPO && bud_ok) begin
          state_next = S_BUD_CHK;
        end else begin
          state_next = S_INS;
        end
      end
      S_BUD_CHK: begin
        if (rd.used && rd.ord == ord) begin
          state_next = S_RM0;
        end else begin
          state_next = S_INS;
        end
      end
      S_MERGE: state_next = S_ADD_LOOP;
      S_INS: begin
        we         = 1'b1;
        waddr      = pg[PW-1:0];
        wdata.used = 1'b1;
        wdata.ord  = ord;
        wdata.prev = NIL;
        wdata.next = ins_head;
        if (ins_head < NIL) begin
          state_next = S_INS_RD;
        end else begin
          state_next = add_ret;
        end
      end
      S_INS_RD: begin
        raddr      = ih[PW-1:0];
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        we         = 1'b1;
        waddr      = ih[PW-1:0];
        wdata      = rd;
        wdata.prev = LW'(pg);
        state_next = add_ret;
      end
      S_RM0: begin
        if (!rm_ok) begin
          state_next = rm_ret;
        end else begin
          we         = 1'b1;
          waddr      = rv;
          wdata.used = 1'b0;
          wdata.ord  = '0;
          wdata.prev = rd.prev;
          wdata.next = rd.next;
          if (rd.prev < NIL) begin
            state_next = S_RMP_RD;
          end else if (rd.next < NIL) begin
            state_next = S_RMN_RD;
          end else begin
            state_next = rm_ret;
          end
        end
      end
      S_RMP_RD: begin
        raddr      = rp[PW-1:0];
        state_next = S_RMP_WR;
      end
      S_RMP_WR: begin
        we         = 1'b1;
        waddr      = rp[PW-1:0];
        wdata      = rd;
        wdata.next = rn;
        if (rn < NIL) begin
          state_next = S_RMN_RD;
        end else begin
          state_next = rm_ret;
        end
      end
      S_RMN_RD: begin
        raddr      = rn[PW-1:0];
        state_next = S_RMN_WR;
      end
      S_RMN_WR: begin
        we         = 1'b1;
        waddr      = rn[PW-1:0];
        wdata      = rd;
        wdata.prev = rp;
        state_next = rm_ret;
      end
      S_DONE: begin
        if (ctl.rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // list heads, counts and running total
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ORDER_LEVELS; i++) begin
        list_head[i]  <= NIL;
        list_count[i] <= '0;
      end
      total <= '0;
      clr   <= '0;
    end else begin
      if (state == S_CLEAR) begin
        clr <= clr + PW'(1);
      end
      if (state == S_INS) begin
        list_head[ord[IW-1:0]]  <= LW'(pg);
        list_count[ord[IW-1:0]] <= list_count[ord[IW-1:0]] + LW'(1);
        total <= total + (TOTAL_W'(1) << ord);
      end
      if (state == S_RM0 && rm_ok) begin
        list_count[rd.ord[IW-1:0]] <= list_count[rd.ord[IW-1:0]] - LW'(1);
        total <= total - (TOTAL_W'(1) << rd.ord);
        if (!(rd.prev < NIL)) begin
          list_head[rd.ord[IW-1:0]] <= rd.next;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (ctl.start) begin
          status <= 1'b0;
          gpage  <= '0;
          gorder <= '0;
          aord   <= '0;
          pages  <= (AW'(req.byte_count) + MASK) >> PAGE_BITS;
          rstart <= (AW'(req.base_address) + MASK) & ~MASK;
          rend   <= (AW'(req.base_address) + AW'(req.byte_count)) & ~MASK;
          pg     <= XW'(req.page_number);
          ctx    <= CTX_FREE;
        end
      end
      S_AORD: begin
        if (aord_step) begin
          aord <= aord + OW'(1);
        end else begin
          h <= aord;
        end
      end
      S_ASCAN: begin
        if (h < MAXO && cnt_zero) begin
          h <= h + OW'(1);
        end else if (h < MAXO && scan_head < NIL) begin
          blk  <= scan_head[PW-1:0];
          rv   <= scan_head[PW-1:0];
          rret <= RET_ALLOC;
        end else begin
          status <= 1'b1;
        end
      end
      S_SPLIT: begin
        if (h > aord) begin
          h   <= h_dec;
          pg  <= split_pg;
          ord <= h_dec;
          ctx <= CTX_SPLIT;
        end
      end
      S_AFIN_WR: begin
        gpage  <= blk;
        gorder <= aord;
      end
      S_F_CHK: ord <= rd.ord;
      S_R_CHK: begin
        pfn <= XW'(pfn_start);
        n   <= XW'(lastc - pfn_start);
        al  <= '0;
        mx  <= TOPO;
        ctx <= CTX_RANGE;
      end
      S_R_BLK: begin
        if (al_step) begin
          al <= al + OW'(1);
        end
        if (mx_step) begin
          mx <= mx - OW'(1);
        end
        if (!al_step && !mx_step) begin
          al  <= r_min;
          pg  <= pfn;
          ord <= r_min;
        end
      end
      S_R_NEXT: begin
        pfn <= pfn + al_pow;
        n   <= n - al_pow;
        al  <= '0;
        mx  <= TOPO;
      end
      S_ADD_LOOP: rv <= bud[PW-1:0];
      S_BUD_CHK:  rret <= RET_MERGE;
      S_MERGE: begin
        pg  <= pg & bud;
        ord <= ord + OW'(1);
      end
      S_INS: ih <= ins_head;
      S_RM0: begin
        rp <= rd.prev;
        rn <= rd.next;
      end
      default: ;
    endcase
  end

  assign sts.idle = state == S_IDLE;
  assign sts.done = (state == S_DONE) && ctl.rsp_free;

  assign rsp.status          = status;
  assign rsp.granted_page    = PAGE_FIELD_W'(gpage);
  assign rsp.granted_order   = ORDER_FIELD_W'(gorder);
  assign rsp.free_page_total = total;

  `BPA_ASSERT(a_idle_no_write, (state != S_IDLE) || !we)
  `BPA_ASSERT(a_clear_zero, (state != S_CLEAR) || (we && (wdata == '0)))
  `BPA_ASSERT_NEXT(a_start_leaves_idle, ctl.start, state != S_IDLE)
  `BPA_ASSERT_NEXT(a_ins_head, state == S_INS, list_head[$past(ord[IW-1:0])] == LW'($past(pg)))

endmodule

// ===== rtl/core/buddy_page_allocator.sv =====
// allocate rounds the size up to an order, skips empty lists, unlinks the head block and
// splits it down a level at a time; free merges with a free buddy level by level
// range free: an alignment search, then the free sequence for each block
// one request in flight; the next is taken the cycle after the response registers
// after reset a clearing pass writes every page entry before the first request is
// taken; list heads, counts and the total clear at once
// ----------------------------------------------------------------------------
// buddy_page_allocator
// buddy page allocator with per-order free lists and a registered response
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int NUM_PAGES = 4096,
  parameter int ORDER_LEVELS = 11,
  parameter int PAGE_BITS = 12
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  request_t  req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output response_t rsp
);

  eng_in_t   ctl;
  eng_out_t  sts;
  response_t eng_rsp;

  assign req_ready    = sts.idle;
  assign ctl.start    = req_valid && sts.idle;
  assign ctl.rsp_free = !rsp_valid || rsp_ready;

  bpa_engine #(
    .NUM_PAGES    (NUM_PAGES),
    .ORDER_LEVELS (ORDER_LEVELS),
    .PAGE_BITS    (PAGE_BITS)
  ) u_engine (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .req (req),
    .sts (sts),
    .rsp (eng_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (sts.done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sts.done) begin
      rsp <= eng_rsp;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// buddy page allocator testbench
// drives allocate, free, free range and unused-opcode requests through the
// valid/ready request channel with random idle bursts on both sides. an
// internal model of the free lists works out each response, and every
// response is checked field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bpa_pkg::*;

  localparam int NPAGES = 4096;
  localparam int NORDERS = 11;
  localparam int PSHIFT = 12;
  localparam int NIL = NPAGES;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  request_t  req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  response_t rsp;

  // model of the free lists
  int          nxt_pg [NPAGES];
  int          prv_pg [NPAGES];
  int          blk_ord [NPAGES];
  bit          listed [NPAGES];
  bit          ord_known [NPAGES];
  int          head_pg [NORDERS];
  int unsigned blk_count [NORDERS];
  int unsigned pages_free;

  response_t   pending_rsp [$];
  int          granted_pool [$];
  bit          quiet = 1'b0;
  int          errors = 0;
  int          n_alloc = 0, n_alloc_fail = 0, n_free = 0, n_range = 0, n_nop = 0;

  buddy_page_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void list_push(int pg, int o);
    int h;
    h = head_pg[o];
    blk_count[o]++;
    pages_free += 1 << o;
    blk_ord[pg] = o;
    ord_known[pg] = 1'b1;
    listed[pg] = 1'b1;
    prv_pg[pg] = NIL;
    nxt_pg[pg] = h;
    if (h < NIL) prv_pg[h] = pg;
    head_pg[o] = pg;
  endfunction

  function automatic void list_unlink(int pg);
    int o, p, n;
    o = blk_ord[pg];
    p = prv_pg[pg];
    n = nxt_pg[pg];
    if (o >= NORDERS) return;
    blk_count[o]--;
    pages_free -= 1 << o;
    if (p < NIL) nxt_pg[p] = n;
    else head_pg[o] = n;
    if (n < NIL) prv_pg[n] = p;
    blk_ord[pg] = 0;
    ord_known[pg] = 1'b1;
    listed[pg] = 1'b0;
  endfunction

  function automatic void merge_in(int pg, int o);
    int bud;
    if (pg >= NIL || o >= NORDERS || listed[pg]) return;
    while (o < NORDERS - 1) begin
      bud = pg ^ (1 << o);
      if (bud >= NIL || !listed[bud] || blk_ord[bud] != o) break;
      list_unlink(bud);
      pg = pg & bud;
      o++;
    end
    list_push(pg, o);
  endfunction

  function automatic void release_bytes(logic [63:0] base, logic [63:0] len);
    logic [63:0] mask, lo, hi, pfn, last, n;
    int al, mx;
    mask = (64'd1 << PSHIFT) - 1;
    lo = (base + mask) & ~mask;
    hi = (base + len) & ~mask;
    if (hi <= lo) return;
    pfn = lo >> PSHIFT;
    last = hi >> PSHIFT;
    if (pfn >= NPAGES) return;
    if (last > NPAGES) last = NPAGES;
    n = last - pfn;
    while (n != 0) begin
      al = 0;
      mx = NORDERS - 1;
      while (((pfn >> al) & 1) == 0 && al < NORDERS - 1) al++;
      while ((64'd1 << mx) > n) mx--;
      if (al > mx) al = mx;
      merge_in(int'(pfn), al);
      pfn += 64'd1 << al;
      n -= 64'd1 << al;
    end
  endfunction

  function automatic response_t allocator_result(request_t r);
    response_t   res;
    logic [63:0] pages;
    int          o, h, blk;
    res = '0;
    case (r.opcode)
      OP_ALLOC: begin
        n_alloc++;
        pages = ({32'd0, r.byte_count} + 64'd4095) >> PSHIFT;
        o = 0;
        while ((64'd1 << o) < pages && o < NORDERS) o++;
        h = o;
        while (h < NORDERS && blk_count[h] == 0) h++;
        if (h < NORDERS && head_pg[h] < NIL) begin
          blk = head_pg[h];
          list_unlink(blk);
          while (h > o) begin
            h--;
            merge_in(blk + (1 << h), h);
          end
          blk_ord[blk] = o;
          ord_known[blk] = 1'b1;
          res.granted_page = blk[11:0];
          res.granted_order = o[3:0];
          granted_pool.push_back(blk);
        end else begin
          res.status = 1'b1;
          n_alloc_fail++;
        end
      end
      OP_FREE: begin
        n_free++;
        if (r.page_number < NIL) merge_in(int'(r.page_number), blk_ord[r.page_number]);
      end
      OP_RANGE: begin
        n_range++;
        release_bytes({32'd0, r.base_address}, {32'd0, r.byte_count});
      end
      default: n_nop++;
    endcase
    res.free_page_total = pages_free[12:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic send_request(request_t r);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    pending_rsp.push_back(allocator_result(r));
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic request_t make_req(opcode_t op, int pg, logic [31:0] base,
                                        logic [31:0] cnt);
    request_t r;
    r.opcode = op;
    r.page_number = pg[11:0];
    r.base_address = base;
    r.byte_count = cnt;
    return r;
  endfunction

  // a page whose recorded order has been written, or -1
  function automatic int known_page();
    int p;
    if (granted_pool.size() != 0 && $urandom_range(0, 9) != 0) begin
      p = $urandom_range(0, granted_pool.size() - 1);
      known_page = granted_pool[p];
      granted_pool.delete(p);
      return known_page;
    end
    p = $urandom_range(0, NPAGES - 1);
    for (int i = 0; i < NPAGES; i++)
      if (ord_known[(p + i) % NPAGES]) return (p + i) % NPAGES;
    return -1;
  endfunction

  task automatic test_edge_cases;
    int g;
    send_request(make_req(OP_ALLOC, 0, 0, 32'd1));            // empty store
    send_request(make_req(OP_NOP, 12'hfff, '1, '1));
    send_request(make_req(OP_RANGE, 0, 32'd0, 32'd0));         // empty range
    send_request(make_req(OP_RANGE, 0, 32'hffff_f000, '1));    // beyond capacity
    send_request(make_req(OP_RANGE, 0, 32'd0, 32'h0100_0000)); // whole store
    send_request(make_req(OP_ALLOC, 0, 0, 32'd0));
    send_request(make_req(OP_ALLOC, 0, 0, 32'd4096));
    send_request(make_req(OP_ALLOC, 0, 0, 32'd4097));
    send_request(make_req(OP_ALLOC, 0, 0, '1));                // too big
    send_request(make_req(OP_ALLOC, 0, 0, 32'h0040_0000));     // largest order
    send_request(make_req(OP_ALLOC, 0, 0, 32'h0040_0001));
    drain();
    while (granted_pool.size() != 0) begin
      g = granted_pool.pop_front();
      send_request(make_req(OP_FREE, g, 0, 0));
      send_request(make_req(OP_FREE, g, 0, 0));                // double free
    end
    send_request(make_req(OP_RANGE, 0, 32'h0000_1801, 32'h0000_6000));
    send_request(make_req(OP_RANGE, 0, 32'h00ff_e000, 32'h0001_0000));
    send_request(make_req(OP_RANGE, 0, 32'h0000_0000, 32'h0080_0000)); // overlap
    send_request(make_req(OP_ALLOC, 0, 0, 32'd1));
    send_request(make_req(OP_FREE, 12'hffe, 0, 0));
  endtask

  task automatic random_request;
    int          k, pg;
    logic [31:0] base, cnt;
    k = $urandom_range(0, 99);
    if (k < 45) begin
      cnt = (k < 3) ? $urandom() : $urandom_range(0, 1 << $urandom_range(0, 23));
      send_request(make_req(OP_ALLOC, $urandom_range(0, 4095), $urandom(), cnt));
    end else if (k < 82) begin
      pg = known_page();
      if (pg >= 0) send_request(make_req(OP_FREE, pg, $urandom(), $urandom()));
    end else if (k < 95) begin
      base = (k < 85) ? $urandom() : {8'd0, 12'($urandom_range(0, 4095)), 12'($urandom())};
      cnt = (k < 87) ? $urandom() : $urandom_range(0, 1 << $urandom_range(8, 18));
      send_request(make_req(OP_RANGE, $urandom_range(0, 4095), base, cnt));
    end else begin
      send_request(make_req(OP_NOP, $urandom_range(0, 4095), $urandom(), $urandom()));
    end
  endtask

  task automatic test_random_traffic(int items);
    for (int i = 0; i < items; i++) begin
      random_request();
      if (i == items / 2) drain();
    end
  endtask

  task automatic test_quiet_tail(int items);
    quiet = 1'b1;
    for (int i = 0; i < items; i++) random_request();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_edge_cases();
    drain();
    test_random_traffic(1800);
    test_quiet_tail(200);
    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d allocates (%0d refused), %0d frees, %0d range frees, %0d no-ops",
             n_alloc, n_alloc_fail, n_free, n_range, n_nop);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    head_pg = '{default: NIL};
    blk_count = '{default: 0};
    pages_free = 0;
  end

  always @(posedge clk) begin
    if (quiet || rst) begin
      rsp_ready <= 1'b1;
    end else if (!rsp_ready || $urandom_range(0, 7) == 0) begin
      rsp_ready <= $urandom_range(0, 1);
    end
  end

  always @(posedge clk) begin
    response_t exp_rsp;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (rsp.status !== exp_rsp.status)
          report_mismatch($sformatf("status %0b, want %0b", rsp.status, exp_rsp.status));
        if (rsp.granted_page !== exp_rsp.granted_page)
          report_mismatch($sformatf("granted_page %0d, want %0d",
                                    rsp.granted_page, exp_rsp.granted_page));
        if (rsp.granted_order !== exp_rsp.granted_order)
          report_mismatch($sformatf("granted_order %0d, want %0d",
                                    rsp.granted_order, exp_rsp.granted_order));
        if (rsp.free_page_total !== exp_rsp.free_page_total)
          report_mismatch($sformatf("free_page_total %0d, want %0d",
                                    rsp.free_page_total, exp_rsp.free_page_total));
      end
    end
  end

endmodule
